### src/sts_pkg.sv
`timescale 1ns / 1ps
package sts_pkg;

    localparam int DATA_W        = 32;   // table word and key
    localparam int IDX_W         = 9;    // entry_index / found_index
    localparam int CNT_W         = 10;   // entry_count register
    localparam int DEFAULT_DEPTH = 512;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

### src/sts_table.sv
`timescale 1ns / 1ps
module sts_table #(
    parameter int DEPTH = sts_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [sts_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [sts_pkg::DATA_W-1:0] o_rd_data
);

    logic [sts_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [sts_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/sts_ctrl.sv
`timescale 1ns / 1ps
module sts_ctrl #(
    parameter int TABLE_DEPTH = sts_pkg::DEFAULT_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [sts_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [sts_pkg::DATA_W-1:0] i_data_value,
    input  logic [sts_pkg::CNT_W-1:0]  i_entry_count,
    // table RAM
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [sts_pkg::DATA_W-1:0] o_wr_data,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [sts_pkg::DATA_W-1:0] i_rd_data,
    // result
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [sts_pkg::IDX_W-1:0]  o_found_index
);

    // bounds held as lower and upper+1, both non-negative, wide enough for the depth
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = sts_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } t_state;

    t_state                     r_state, n_state;
    logic [PW-1:0]              r_lo, n_lo;
    logic [PW-1:0]              r_hp1, n_hp1;
    logic [PW-1:0]              r_mid, n_mid;
    logic [sts_pkg::DATA_W-1:0] r_key, n_key;
    logic                       r_hit, n_hit;
    logic                       r_out_valid, n_out_valid;
    logic                       r_found, n_found;
    logic [IW-1:0]              r_found_index, n_found_index;

    logic [PW-1:0] w_count;
    logic [PW:0]   w_sum_less;
    logic [PW:0]   w_sum_more;
    logic          w_eq;
    logic          w_lt;
    logic          w_slot_free;
    logic          w_done;
    logic          w_done_hit;
    logic          w_rd_en;

    always_comb begin
        if (32'(i_entry_count) > 32'(TABLE_DEPTH)) begin
            w_count = PW'(TABLE_DEPTH);
        end else begin
            w_count = PW'(i_entry_count);
        end
    end

    // both candidate next probes are formed alongside the compare
    assign w_sum_less  = {1'b0, r_mid} + {1'b0, r_hp1};
    assign w_sum_more  = {1'b0, r_lo} + {1'b0, r_mid} - {{PW{1'b0}}, 1'b1};
    assign w_eq        = (i_rd_data == r_key);
    assign w_lt        = ($signed(i_rd_data) < $signed(r_key));
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_lo          = r_lo;
        n_hp1         = r_hp1;
        n_mid         = r_mid;
        n_key         = r_key;
        n_hit         = r_hit;
        n_out_valid   = r_out_valid;
        n_found       = r_found;
        n_found_index = r_found_index;
        w_done        = 1'b0;
        w_done_hit    = 1'b0;
        w_rd_en       = 1'b0;
        o_wr_en       = 1'b0;
        o_in_ready    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == sts_pkg::OP_WRITE) begin
                        o_wr_en = (32'(i_entry_index) < 32'(TABLE_DEPTH));
                    end else if (w_count == '0) begin
                        w_done = 1'b1;
                    end else begin
                        n_key   = i_data_value;
                        n_lo    = '0;
                        n_hp1   = w_count;
                        n_mid   = (w_count - 1'b1) >> 1;
                        w_rd_en = 1'b1;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_eq) begin
                    w_done     = 1'b1;
                    w_done_hit = 1'b1;
                end else if (w_lt) begin
                    if (({1'b0, r_mid} + 1'b1) < {1'b0, r_hp1}) begin
                        n_lo    = r_mid + 1'b1;
                        n_mid   = w_sum_less[PW:1];
                        w_rd_en = 1'b1;
                    end else begin
                        w_done = 1'b1;
                    end
                end else begin
                    if (r_lo < r_mid) begin
                        n_hp1   = r_mid;
                        n_mid   = w_sum_more[PW:1];
                        w_rd_en = 1'b1;
                    end else begin
                        w_done = 1'b1;
                    end
                end
            end
            S_HOLD: begin
                w_done     = 1'b1;
                w_done_hit = r_hit;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // finished result waits in HOLD while the output register is occupied
        if (w_done) begin
            n_hit = w_done_hit;
            if (w_slot_free) begin
                n_out_valid   = 1'b1;
                n_found       = w_done_hit;
                n_found_index = w_done_hit ? IW'(r_mid) : '0;
                n_state       = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    assign o_wr_addr = AW'(i_entry_index);
    assign o_wr_data = i_data_value;
    assign o_rd_en   = w_rd_en;
    assign o_rd_addr = n_mid[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo          <= n_lo;
        r_hp1         <= n_hp1;
        r_mid         <= n_mid;
        r_key         <= n_key;
        r_hit         <= n_hit;
        r_found       <= n_found;
        r_found_index <= n_found_index;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;

endmodule

### src/sorted_table_binary_search_core.sv
`timescale 1ns / 1ps
// Binary search over a table of signed 32-bit words held in one single-port-read RAM.
// A write transfer stores i_data_value at i_entry_index (indexes at or beyond
// TABLE_DEPTH are dropped). A search transfer issues its first probe when it is
// accepted; each probe is one RAM read whose data decides the next address, which
// makes at most floor(log2(count))+1 probes, and none for an empty table. The result
// goes to an output register, and the next item is taken as soon as the result is
// in that register. The table is not cleared
// at reset: entries read before being written return whatever the RAM holds.
// entry_count (saturated to TABLE_DEPTH) may only be written while the block is idle.
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = sts_pkg::DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sts_pkg::CNT_W-1:0]  i_cfg_entry_count,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [sts_pkg::IDX_W-1:0]  i_entry_index,
    input  logic signed [sts_pkg::DATA_W-1:0] i_data_value,
    // results
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [sts_pkg::IDX_W-1:0]  o_found_index
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [sts_pkg::CNT_W-1:0]  r_entry_count;
    logic                       w_wr_en;
    logic [AW-1:0]              w_wr_addr;
    logic [sts_pkg::DATA_W-1:0] w_wr_data;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    logic [sts_pkg::DATA_W-1:0] w_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entry_count <= i_cfg_entry_count;
        end
    end

    sts_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_data_value  (i_data_value),
        .i_entry_count (r_entry_count),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_found_index (o_found_index)
    );

    // table is written only by an accepted write item
    a_wr_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (i_in_valid && o_in_ready && (i_op == sts_pkg::OP_WRITE)))
        else $error("table written without a write transfer");

    // a write and a probe never share a cycle
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("table read and write in the same cycle");

    // a miss reports index zero
    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_found_index == '0))
        else $error("miss with non-zero index");

    // a hit lies inside the searched range
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (32'(o_found_index) < 32'(r_entry_count)))
        else $error("hit index beyond entry count");

endmodule
